### design/mid_pkg.sv
`timescale 1ns / 1ps

package mid_pkg;

  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH);

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_NOINV = 1'b1;

  typedef struct packed {
    logic [WIDTH-1:0] dividend;
    logic [WIDTH-1:0] divisor;
  } in_word_t;

  typedef struct packed {
    logic [WIDTH-1:0] quotient;
    logic             status;
  } out_word_t;

  typedef enum logic {
    ALU_DBLADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [WIDTH-1:0] a;
    logic [WIDTH-1:0] b;
    logic [WIDTH-1:0] m;
  } alu_req_t;

endpackage

### design/mid_alu.sv
`timescale 1ns / 1ps

module mid_alu import mid_pkg::*; (
  input  alu_req_t         req,
  output logic [WIDTH-1:0] res
);

  logic [WIDTH+1:0] sum;
  logic [WIDTH+1:0] m1;
  logic [WIDTH+1:0] m2;
  logic [WIDTH:0]   diff;
  logic [WIDTH-1:0] diff_fix;

  // (2a + b) mod m, operands below m so sum < 3m
  assign sum = {1'b0, req.a, 1'b0} + {2'b00, req.b};
  assign m1  = {2'b00, req.m};
  assign m2  = {1'b0, req.m, 1'b0};

  // (a - b) mod m
  assign diff     = {1'b0, req.a} - {1'b0, req.b};
  assign diff_fix = diff[WIDTH-1:0] + req.m;

  always_comb begin
    res = '0;
    unique case (req.op)
      ALU_DBLADD: begin
        if (sum >= m2) begin
          res = WIDTH'(sum - m2);
        end else if (sum >= m1) begin
          res = WIDTH'(sum - m1);
        end else begin
          res = sum[WIDTH-1:0];
        end
      end
      ALU_SUB: begin
        res = diff[WIDTH] ? diff_fix : diff[WIDTH-1:0];
      end
      default: res = '0;
    endcase
  end

endmodule

### design/modular_inverse_divider.sv
`timescale 1ns / 1ps
// Modular divider: quotient = dividend * divisor^-1 mod modulus.
// Input channel in_valid/in_stall/in_data carries one word {dividend, divisor};
// result channel out_valid/out_stall/out_data carries {quotient, status}.
// A word moves at a clock edge with valid high and stall low.
// cfg_we/cfg_wdata writes the modulus; write it only while the block is idle.
// One word is processed at a time; in_stall is high from accept until the
// result is handed to the output register. A word passes through two
// modulus reductions (dividend, then divisor), the Euclid steps and a final
// multiply. Each reduction and each Euclid step runs on a shift-subtract
// divider, and the double-and-add modular unit is shared by the coefficient
// update and the multiply.
// A held result waits in the output register while the next word is worked
// on; if out_stall keeps it, the finished word waits before the output.
// A zero modulus or gcd(divisor, modulus) != 1 gives status 1, quotient 0.
// Synchronous active-low reset: idle, no result pending, modulus = 2.

module modular_inverse_divider import mid_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_word_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_word_t        out_data,
  input  logic             cfg_we,
  input  logic [WIDTH-1:0] cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALIGN,
    S_DIV,
    S_POST,
    S_CHECK,
    S_MUL,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    PH_RED_X,
    PH_RED_D,
    PH_EUC
  } phase_t;

  state_t           state_r;
  phase_t           phase_r;
  logic [WIDTH-1:0] modulus_r;
  logic [WIDTH-1:0] x_r;
  logic [WIDTH-1:0] d_r;
  logic [WIDTH-1:0] rem_r;
  logic [WIDTH-1:0] s_r;
  logic [WIDTH-1:0] r0_r;
  logic [WIDTH-1:0] r1_r;
  logic [WIDTH-1:0] t0_r;
  logic [WIDTH-1:0] t1_r;
  logic [WIDTH-1:0] acc_r;
  logic [WIDTH-1:0] mult_r;
  logic [CNT_W-1:0] k_r;
  out_word_t        res_r;
  out_word_t        out_data_r;
  logic             out_valid_r;

  logic [WIDTH-1:0] s_dbl;
  logic             align_go;
  logic             div_ge;
  alu_req_t         alu_req;
  logic [WIDTH-1:0] alu_res;

  assign s_dbl    = {s_r[WIDTH-2:0], 1'b0};
  assign align_go = !s_r[WIDTH-1] && (s_dbl <= rem_r);
  assign div_ge   = (rem_r >= s_r);

  always_comb begin
    alu_req.op = ALU_DBLADD;
    alu_req.a  = acc_r;
    alu_req.b  = '0;
    alu_req.m  = modulus_r;
    unique case (state_r)
      S_DIV: begin
        alu_req.b = div_ge ? t1_r : '0;
      end
      S_POST: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = t0_r;
        alu_req.b  = acc_r;
      end
      S_MUL: begin
        alu_req.b = mult_r[WIDTH-1] ? x_r : '0;
      end
      default: ;
    endcase
  end

  mid_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_RED_X;
      out_valid_r <= 1'b0;
      modulus_r   <= WIDTH'(2);
    end else begin
      if (cfg_we) begin
        modulus_r <= cfg_wdata;
      end
      if (out_valid_r && !out_stall && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            x_r <= in_data.dividend;
            d_r <= in_data.divisor;
            if (modulus_r == '0) begin
              res_r.quotient <= '0;
              res_r.status   <= STATUS_NOINV;
              state_r        <= S_FIN;
            end else begin
              rem_r   <= in_data.dividend;
              s_r     <= modulus_r;
              k_r     <= '0;
              phase_r <= PH_RED_X;
              state_r <= S_ALIGN;
            end
          end
        end
        S_ALIGN: begin
          if (align_go) begin
            s_r <= s_dbl;
            k_r <= k_r + CNT_W'(1);
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_ge) begin
            rem_r <= rem_r - s_r;
          end
          s_r <= s_r >> 1;
          if (phase_r == PH_EUC) begin
            acc_r <= alu_res;
          end
          if (k_r == '0) begin
            state_r <= S_POST;
          end else begin
            k_r <= k_r - CNT_W'(1);
          end
        end
        S_POST: begin
          unique case (phase_r)
            PH_RED_X: begin
              x_r     <= rem_r;
              rem_r   <= d_r;
              s_r     <= modulus_r;
              k_r     <= '0;
              phase_r <= PH_RED_D;
              state_r <= S_ALIGN;
            end
            PH_RED_D: begin
              r0_r    <= modulus_r;
              r1_r    <= rem_r;
              t0_r    <= '0;
              t1_r    <= (modulus_r == WIDTH'(1)) ? '0 : WIDTH'(1);
              state_r <= S_CHECK;
            end
            PH_EUC: begin
              r0_r    <= r1_r;
              r1_r    <= rem_r;
              t0_r    <= t1_r;
              t1_r    <= alu_res;
              state_r <= S_CHECK;
            end
            default: state_r <= S_IDLE;
          endcase
        end
        S_CHECK: begin
          if (r1_r == '0) begin
            if (r0_r == WIDTH'(1)) begin
              acc_r   <= '0;
              mult_r  <= t0_r;
              k_r     <= CNT_W'(WIDTH - 1);
              state_r <= S_MUL;
            end else begin
              res_r.quotient <= '0;
              res_r.status   <= STATUS_NOINV;
              state_r        <= S_FIN;
            end
          end else begin
            rem_r   <= r0_r;
            s_r     <= r1_r;
            k_r     <= '0;
            acc_r   <= '0;
            phase_r <= PH_EUC;
            state_r <= S_ALIGN;
          end
        end
        S_MUL: begin
          acc_r  <= alu_res;
          mult_r <= mult_r << 1;
          if (k_r == '0) begin
            res_r.quotient <= alu_res;
            res_r.status   <= STATUS_OK;
            state_r        <= S_FIN;
          end else begin
            k_r <= k_r - CNT_W'(1);
          end
        end
        S_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_data_r  <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
